@@ rtl/core/swd_sm_pkg.sv @@
`default_nettype none

package swd_sm_pkg;

  localparam int unsigned PAYLOAD_WORDS = 18;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned COUNT_W = 6;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  localparam logic [INDEX_W:0] LAST_INDEX = (INDEX_W + 1)'(PAYLOAD_WORDS - 1);

  // sign-magnitude to two's complement, negative zero maps to zero
  function automatic logic signed [WORD_W-1:0] sm_to_twos(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] mag;
    mag = {1'b0, w[WORD_W-2:0]};
    if (w[WORD_W-1]) begin
      return signed'(WORD_W'(-mag));
    end
    return signed'(mag);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sync_word_deframer_sign_magnitude_unit.sv @@
// a byte that completes a word shows its result in the cycle after acceptance; the single
// result register refills in the cycle it drains; one byte per cycle unless output stalls
// a byte that completes no word only updates the framing state
// reset (synchronous, active high): hunting for the header, no sync byte seen, result empty
`default_nettype none

module sync_word_deframer_sign_magnitude_unit (
  input  wire                                           clk,
  input  wire                                           rst,
  input  wire                                           byte_valid,
  output logic                                          byte_ready,
  input  wire  [swd_sm_pkg::BYTE_W-1:0]                 rx_byte,
  output logic                                          word_valid,
  input  wire                                           word_ready,
  output logic signed [swd_sm_pkg::WORD_W-1:0]          word_value,
  output logic [swd_sm_pkg::INDEX_W-1:0]                word_index,
  output logic                                          frame_last
);

  logic                               in_frame;
  logic                               prev_was_sync;
  logic [swd_sm_pkg::COUNT_W-1:0]     byte_count;
  logic [swd_sm_pkg::BYTE_W-1:0]      high_byte;

  logic                               accept;
  logic                               is_sync;
  logic                               word_done;
  logic [swd_sm_pkg::INDEX_W-1:0]     idx;
  logic                               last;

  assign byte_ready = !word_valid || word_ready;
  assign accept     = byte_valid && byte_ready;
  assign is_sync    = (rx_byte == swd_sm_pkg::SYNC_BYTE);
  assign idx        = byte_count[swd_sm_pkg::COUNT_W-1:1];
  assign last       = ({1'b0, idx} >= swd_sm_pkg::LAST_INDEX);
  assign word_done  = in_frame && byte_count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      prev_was_sync <= 1'b0;
      byte_count    <= '0;
      high_byte     <= '0;
      word_valid    <= 1'b0;
    end else begin
      if (word_valid && word_ready) begin
        word_valid <= 1'b0;
      end
      if (accept) begin
        if (!in_frame) begin
          if (prev_was_sync && is_sync) begin
            in_frame      <= 1'b1;
            byte_count    <= '0;
            prev_was_sync <= 1'b0;
          end else begin
            prev_was_sync <= is_sync;
          end
        end else if (!byte_count[0]) begin
          high_byte  <= rx_byte;
          byte_count <= byte_count + 1'b1;
        end else begin
          word_valid <= 1'b1;
          if (last) begin
            in_frame      <= 1'b0;
            prev_was_sync <= 1'b0;
            byte_count    <= '0;
          end else begin
            byte_count <= byte_count + 1'b1;
          end
        end
      end
    end
  end

  // result payload, loaded with the low byte of each word
  always_ff @(posedge clk) begin
    if (accept && word_done) begin
      word_value <= swd_sm_pkg::sm_to_twos({high_byte, rx_byte});
      word_index <= idx;
      frame_last <= last;
    end
  end

endmodule

`default_nettype wire

@@ verif/deframer_words_pkg.sv @@
package deframer_words_pkg;

  import swd_sm_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic [INDEX_W-1:0]       index;
    logic                     last_word;
  } decoded_word_t;

  class word_scoreboard;

    bit                in_frame;
    bit                prev_sync;
    bit [COUNT_W-1:0]  byte_count;
    bit [BYTE_W-1:0]   high_byte;
    decoded_word_t     pending_words[$];
    int                errors;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int waiting();
      return pending_words.size();
    endfunction

    // advance the framing state by one accepted byte, queue the word it completes
    function void note_byte(logic [BYTE_W-1:0] b);
      decoded_word_t    w;
      logic [WORD_W-1:0] raw;
      logic [WORD_W-1:0] mag;
      logic [INDEX_W-1:0] idx;
      if (!in_frame) begin
        if (prev_sync && b == SYNC_BYTE) begin
          in_frame   = 1'b1;
          byte_count = '0;
          prev_sync  = 1'b0;
        end else begin
          prev_sync = (b == SYNC_BYTE);
        end
        return;
      end
      if (!byte_count[0]) begin
        high_byte  = b;
        byte_count = byte_count + 1'b1;
        return;
      end
      idx         = byte_count[COUNT_W-1:1];
      raw         = {high_byte, b};
      mag         = {1'b0, raw[WORD_W-2:0]};
      // negative zero folds to zero here as well
      w.value     = raw[WORD_W-1] ? WORD_W'(0 - mag) : mag;
      w.index     = idx;
      w.last_word = (int'(idx) + 1 >= int'(PAYLOAD_WORDS));
      pending_words.push_back(w);
      byte_count = byte_count + 1'b1;
      if (w.last_word) begin
        in_frame   = 1'b0;
        prev_sync  = 1'b0;
        byte_count = '0;
      end
    endfunction

    function void check_word(logic signed [WORD_W-1:0] value, logic [INDEX_W-1:0] index,
                             logic last_word);
      decoded_word_t w;
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word: value %0d index %0d last %0b",
                       value, index, last_word));
        return;
      end
      w = pending_words.pop_front();
      if (value !== w.value || index !== w.index || last_word !== w.last_word)
        flag($sformatf("word mismatch: expected value %0d index %0d last %0b, got value %0d index %0d last %0b",
                       w.value, w.index, w.last_word, value, index, last_word));
    endfunction

  endclass

endpackage

@@ verif/tb.sv @@
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import swd_sm_pkg::*;
  import deframer_words_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic word_ready = 1'b0;
  logic byte_ready;
  logic word_valid;
  logic signed [WORD_W-1:0] word_value;
  logic [INDEX_W-1:0] word_index;
  logic frame_last;

  word_scoreboard sb = new();
  int bytes_sent = 0;
  int quiet_cycles = 0;
  logic calm;

  // a long stretch with no idling on either side
  assign calm = (bytes_sent >= 700) && (bytes_sent < 1100);

  always #5 clk = ~clk;

  sync_word_deframer_sign_magnitude_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .rx_byte   (rx_byte),
    .word_valid(word_valid),
    .word_ready(word_ready),
    .word_value(word_value),
    .word_index(word_index),
    .frame_last(frame_last)
  );

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < 22) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte    <= b;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
  endtask

  always @(posedge clk) begin
    word_ready <= calm || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && byte_ready) sb.note_byte(rx_byte);
    if (!rst && word_valid && word_ready) sb.check_word(word_value, word_index, frame_last);
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (word_valid && word_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BYTE_W-1:0] directed[$];
    int kind;
    int n;
    // noise, a lone sync byte, the header, then a run of 0xFF taken as payload,
    // negative zero and the magnitude extremes
    directed = '{8'h00, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00,
                 8'h7F, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h01, 8'h00, 8'h00, 8'hFF,
                 8'h7F, 8'h01, 8'h80};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_byte(directed[i]);

    while (bytes_sent < directed.size() + RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // well-formed frame, sometimes preceded by a little noise
        n = $urandom_range(3);
        repeat (n) send_byte(8'($urandom_range(254)));
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        repeat (2 * PAYLOAD_WORDS) begin
          case ($urandom_range(9))
            0, 1:    send_byte(8'hFF);
            2:       send_byte(8'h00);
            3:       send_byte(8'h80);
            4:       send_byte(8'h7F);
            default: send_byte(8'($urandom_range(255)));
          endcase
        end
      end else if (kind < 90) begin
        // broken header
        send_byte(SYNC_BYTE);
        send_byte(8'($urandom_range(254)));
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
    end
    byte_valid <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sync_word_deframer_sign_magnitude_unit.f @@
rtl/core/swd_sm_pkg.sv
rtl/core/sync_word_deframer_sign_magnitude_unit.sv
verif/deframer_words_pkg.sv
verif/tb.sv
